// ===== src/pitch_yaw_to_forward_vector_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef PITCH_YAW_TO_FORWARD_VECTOR_CORE_ASSERT_SVH
`define PITCH_YAW_TO_FORWARD_VECTOR_CORE_ASSERT_SVH

`define PYF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PYF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/pyf_pkg.sv =====
package pyf_pkg;
    localparam int AngW      = 17;
    localparam int OutW      = 16;
    localparam int CW        = 34;
    localparam int AtanSteps = 24;
    localparam int FullTurn  = 46080;
    localparam int QuarterTurn = 11520;
    localparam logic signed [CW-1:0] InvGain = 34'sd652032874;
    localparam logic signed [OutW-1:0] UnitPos = 16'sd16384;
    localparam logic signed [OutW-1:0] UnitNeg = -16'sd16384;

    typedef logic signed [CW-1:0] t_q30;

    typedef struct packed {
        t_q30       x;
        t_q30       y;
        t_q30       z;
        logic [1:0] q;
    } t_rot;

    function automatic t_q30 atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; default: v = 32'h0000007F;
        endcase
        return t_q30'({2'b00, v});
    endfunction
endpackage

// ===== src/pitch_yaw_to_forward_vector_core.sv =====
// Forward unit vector from pitch and yaw angles.
// Request channel: drive i_pitch_deg and i_yaw_deg (degrees * 128, signed)
// with i_start high; a request is taken on any edge where o_busy is low.
// o_busy is always low: the pipeline takes one request every cycle.
// Result channel: o_valid strobes for one cycle with o_forward_x/y/z,
// each a signed unit-vector component scaled by 16384.
// Pipeline stages: the angle reduction (4 stages), one stage per
// CORDIC step, the quadrant fix, and two product/round stages.
// Throughput: one result per cycle. Results keep request order.
// Any 17-bit angle wraps modulo 360 degrees.
// Reset clears all valid bits; requests in flight are dropped.
// The receiver cannot stall; results are presented exactly once.
module pitch_yaw_to_forward_vector_core
    import pyf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic signed [AngW-1:0] i_pitch_deg,
    input  logic signed [AngW-1:0] i_yaw_deg,
    output logic                   o_valid,
    output logic signed [OutW-1:0] o_forward_x,
    output logic signed [OutW-1:0] o_forward_y,
    output logic signed [OutW-1:0] o_forward_z
);
    logic go;
    logic vp_p, vp_y, vc_p, vc_y;
    t_rot rp, ry;
    t_q30 cp, sp, cy, sy;

    assign o_busy = 1'b0;
    assign go = i_start & ~o_busy;

    pyf_prep u_prep_p (.i_clk, .i_rst_n, .i_valid(go), .i_angle(i_pitch_deg),
        .o_valid(vp_p), .o_rot(rp));
    pyf_prep u_prep_y (.i_clk, .i_rst_n, .i_valid(go), .i_angle(i_yaw_deg),
        .o_valid(vp_y), .o_rot(ry));

    pyf_cordic #(.Steps(CORDIC_ITERATIONS)) u_cor_p (.i_clk, .i_rst_n,
        .i_valid(vp_p), .i_rot(rp), .o_valid(vc_p), .o_cos(cp), .o_sin(sp));
    pyf_cordic #(.Steps(CORDIC_ITERATIONS)) u_cor_y (.i_clk, .i_rst_n,
        .i_valid(vp_y), .i_rot(ry), .o_valid(vc_y), .o_cos(cy), .o_sin(sy));

    pyf_combine u_comb (.i_clk, .i_rst_n, .i_valid(vc_p & vc_y),
        .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy),
        .o_valid, .o_x(o_forward_x), .o_y(o_forward_y), .o_z(o_forward_z));
endmodule

// ===== src/pyf_prep.sv =====
module pyf_prep
    import pyf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [AngW-1:0] i_angle,
    output logic                   o_valid,
    output t_rot                   o_rot
);
    logic        r_v1, r_v2, r_v3;
    logic [16:0] r_m;
    logic [1:0]  r_q1, r_q2;
    logic [13:0] r_r;
    logic [30:0] r_rk;
    logic [27:0] r_t;
    logic [16:0] n_m;
    logic [16:0] rem;
    logic [1:0]  q;
    logic [18:0] u;
    logic [39:0] prod;
    logic [13:0] qs;
    t_q30        z;

    always_comb begin
        if (i_angle >= 17'sd46080) begin
            n_m = 17'(i_angle - 17'sd46080);
        end else if (i_angle >= 17'sd0) begin
            n_m = 17'(i_angle);
        end else if (i_angle >= -17'sd46080) begin
            n_m = 17'(i_angle + 18'sd46080);
        end else begin
            n_m = 17'(i_angle + 18'sd92160);
        end
    end

    always_comb begin
        if (r_m >= 17'd34560) begin
            q = 2'd3; rem = r_m - 17'd34560;
        end else if (r_m >= 17'd23040) begin
            q = 2'd2; rem = r_m - 17'd23040;
        end else if (r_m >= 17'd11520) begin
            q = 2'd1; rem = r_m - 17'd11520;
        end else begin
            q = 2'd0; rem = r_m;
        end
    end

    // split pi*2^30 into 23040*146408 + 19106; divide the rest by 512, then by 45
    always_comb begin
        u    = r_t[27:9];
        prod = 40'(u) * 40'd1491309;
        qs   = prod[39:26];
        z    = {3'b000, r_rk + {17'd0, qs}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            o_valid <= r_v3;
        end
        r_m    <= n_m;
        r_r    <= rem[13:0];
        r_q1   <= q;
        r_rk   <= 31'(r_r) * 31'd146408;
        r_t    <= 28'(r_r) * 28'd19106 + 28'd11520;
        r_q2   <= r_q1;
        o_rot.x <= InvGain;
        o_rot.y <= '0;
        o_rot.z <= z;
        o_rot.q <= r_q2;
    end
endmodule

// ===== src/pyf_cordic.sv =====
module pyf_cordic
    import pyf_pkg::*;
#(
    parameter int Steps = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_rot  i_rot,
    output logic  o_valid,
    output t_q30  o_cos,
    output t_q30  o_sin
);
    localparam int N = (Steps > AtanSteps) ? AtanSteps : Steps;
    t_rot r_st [N+1];
    logic [N:0] r_v;

    assign r_st[0] = i_rot;
    assign r_v[0]  = i_valid;

    for (genvar i = 0; i < N; i++) begin : g_stage
        t_rot n_st;
        always_comb begin
            n_st = r_st[i];
            if (!r_st[i].z[CW-1]) begin
                n_st.x = r_st[i].x - (r_st[i].y >>> i);
                n_st.y = r_st[i].y + (r_st[i].x >>> i);
                n_st.z = r_st[i].z - atan_q30(i);
            end else begin
                n_st.x = r_st[i].x + (r_st[i].y >>> i);
                n_st.y = r_st[i].y - (r_st[i].x >>> i);
                n_st.z = r_st[i].z + atan_q30(i);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            r_st[i+1] <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[N];
        end
        case (r_st[N].q)
            2'd0: begin o_cos <= r_st[N].x;  o_sin <= r_st[N].y;  end
            2'd1: begin o_cos <= -r_st[N].y; o_sin <= r_st[N].x;  end
            2'd2: begin o_cos <= -r_st[N].x; o_sin <= -r_st[N].y; end
            default: begin o_cos <= r_st[N].y; o_sin <= -r_st[N].x; end
        endcase
    end
endmodule

// ===== src/pyf_combine.sv =====
module pyf_combine
    import pyf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_q30                   i_cp,
    input  t_q30                   i_sp,
    input  t_q30                   i_cy,
    input  t_q30                   i_sy,
    output logic                   o_valid,
    output logic signed [OutW-1:0] o_x,
    output logic signed [OutW-1:0] o_y,
    output logic signed [OutW-1:0] o_z
);
    logic r_v;
    logic signed [67:0] r_px, r_py;
    logic signed [OutW-1:0] r_z;
    logic signed [67:0] sx, sy;
    logic signed [CW-1:0] sz;

    function automatic logic signed [OutW-1:0] sat(input logic signed [67:0] v);
        if (v > 68'sd16384) return UnitPos;
        if (v < -68'sd16384) return UnitNeg;
        return OutW'(v);
    endfunction

    always_comb begin
        sx = (r_px + (68'sd1 <<< 45)) >>> 46;
        sy = (r_py + (68'sd1 <<< 45)) >>> 46;
        sz = -((i_sp + 34'sd32768) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v <= i_valid;
            o_valid <= r_v;
        end
        r_px <= 68'(i_cp) * 68'(i_cy);
        r_py <= 68'(i_cp) * 68'(i_sy);
        r_z  <= sat(68'(sz));
        o_x  <= sat(sx);
        o_y  <= sat(sy);
        o_z  <= r_z;
    end
endmodule

// ===== src/pyf_checker.sv =====
`include "pitch_yaw_to_forward_vector_core_assert.svh"

module pyf_checker
    import pyf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_busy,
    input logic                   o_valid,
    input logic signed [OutW-1:0] o_forward_x,
    input logic signed [OutW-1:0] o_forward_y,
    input logic signed [OutW-1:0] o_forward_z
);
    `PYF_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    `PYF_ASSERT_IMPL(a_x_range, i_clk, i_rst_n, o_valid, o_forward_x <= UnitPos && o_forward_x >= UnitNeg)
    `PYF_ASSERT_IMPL(a_y_range, i_clk, i_rst_n, o_valid, o_forward_y <= UnitPos && o_forward_y >= UnitNeg)
    `PYF_ASSERT_IMPL(a_z_range, i_clk, i_rst_n, o_valid, o_forward_z <= UnitPos && o_forward_z >= UnitNeg)
    `PYF_ASSERT_NEXT(a_no_out_after_reset, i_clk, 1'b1, !i_rst_n, !o_valid)
endmodule

bind pitch_yaw_to_forward_vector_core pyf_checker u_pyf_checker (.*);
